[rtl/core/dqu_pkg.sv]
// Shared types, constants and helpers for the double-ended queue unit.
package dqu_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int WORD_W   = 32;
	localparam int OCC_W    = 5;

	localparam logic signed [WORD_W-1:0] EMPTY_WORD = {WORD_W{1'b1}};

	localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
	localparam logic [1:0] REQ_PUSH_REAR  = 2'd1;
	localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
	localparam logic [1:0] REQ_POP_REAR   = 2'd3;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_UNDERFLOW = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [1:0]               req_type;
		logic signed [WORD_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] rear_value;
		logic [OCC_W-1:0]         occupancy;
		logic                     is_empty;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_LOAD
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic load;
	} dqu_cmd_t;

	// (base + off) mod CAPACITY, for base < CAPACITY and off <= CAPACITY
	function automatic idx_t wrap_add(input idx_t base, input cnt_t off);
		logic [CNT_W:0] s;
		s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
		if (s >= (CNT_W + 1)'(CAPACITY)) begin
			s = s - (CNT_W + 1)'(CAPACITY);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

[rtl/core/double_ended_queue_unit.sv]
// Double-ended queue unit top level.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_stall  | req_t (req_type, push_value)
//  rsp     | out | rsp_valid/rsp_stall  | rsp_t (status, front/rear, occupancy, is_empty)
//
// Each request passes through capture, state update and store write, store read and
// result load before the next is taken; the registered store read needs its own step.
// The result register lets the next request be taken while a result waits.
// Reset clears head and count; the store itself is not cleared.
// A stalled result holds the load cycle until the register frees.
module double_ended_queue_unit import dqu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	dqu_cmd_t cmd;

	dqu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.cmd      (cmd)
	);

	dqu_datapath u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.req   (req),
		.rsp   (rsp)
	);

endmodule

[rtl/core/dqu_ram.sv]
// Generic RAM: one write port, two registered read ports.
module dqu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

[rtl/core/dqu_datapath.sv]
// Deque datapath: head and count registers, word store and result register.
module dqu_datapath import dqu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  dqu_cmd_t cmd,
	input  req_t     req,
	output rsp_t     rsp
);

	req_t       req_q;
	idx_t       head_q;
	cnt_t       count_q;
	logic [1:0] stat_q;
	rsp_t       rsp_q;

	logic                     is_push;
	logic                     full;
	logic                     empty;
	idx_t                     head_dec;
	idx_t                     wr_addr;
	logic                     wr_en;
	idx_t                     rear_addr;
	logic [WORD_W-1:0]        front_rd;
	logic [WORD_W-1:0]        rear_rd;

	assign is_push   = (req_q.req_type == REQ_PUSH_FRONT) || (req_q.req_type == REQ_PUSH_REAR);
	assign full      = (count_q == cnt_t'(CAPACITY));
	assign empty     = (count_q == '0);
	assign head_dec  = (head_q == '0) ? idx_t'(CAPACITY - 1) : head_q - idx_t'(1);
	assign wr_addr   = (req_q.req_type == REQ_PUSH_FRONT) ? head_dec : wrap_add(head_q, count_q);
	assign wr_en     = cmd.exec && is_push && !full;
	assign rear_addr = wrap_add(head_q, count_q - cnt_t'(1));

	dqu_ram #(
		.WIDTH(WORD_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk    (clk),
		.we     (wr_en),
		.waddr  (wr_addr),
		.wdata  (req_q.push_value),
		.raddr_a(head_q),
		.raddr_b(rear_addr),
		.rdata_a(front_rd),
		.rdata_b(rear_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.exec) begin
			if (is_push) begin
				stat_q <= full ? STAT_OVERFLOW : STAT_OK;
			end else begin
				stat_q <= empty ? STAT_UNDERFLOW : STAT_OK;
			end
		end
		if (cmd.load) begin
			rsp_q.status      <= stat_q;
			rsp_q.front_value <= empty ? EMPTY_WORD : $signed(front_rd);
			rsp_q.rear_value  <= empty ? EMPTY_WORD : $signed(rear_rd);
			rsp_q.occupancy   <= OCC_W'(count_q);
			rsp_q.is_empty    <= empty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			if (is_push) begin
				if (!full) begin
					if (req_q.req_type == REQ_PUSH_FRONT) begin
						head_q <= head_dec;
					end
					count_q <= count_q + cnt_t'(1);
				end
			end else if (!empty) begin
				if (req_q.req_type == REQ_POP_FRONT) begin
					head_q <= wrap_add(head_q, cnt_t'(1));
				end
				count_q <= count_q - cnt_t'(1);
			end
		end
	end

	assign rsp = rsp_q;

endmodule

[rtl/core/dqu_ctrl.sv]
// Deque controller: request sequencing and result handshake.
module dqu_ctrl import dqu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output dqu_cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   load_ok;

	assign load_ok = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (req_valid) state_d = S_EXEC;
			S_EXEC: state_d = S_READ;
			S_READ: state_d = S_LOAD;
			S_LOAD: if (load_ok) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_stall   = 1'b1;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		cmd.load    = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_stall   = 1'b0;
				cmd.capture = req_valid;
			end
			S_EXEC: cmd.exec = 1'b1;
			S_READ: ;
			S_LOAD: cmd.load = load_ok;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

[rtl/core/dqu_checker.sv]
// Port-level checks for the double-ended queue unit, bound to the top level.
module dqu_checker import dqu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result dropped while stalled");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous one in flight");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.is_empty == (rsp.occupancy == '0)))
		else $error("empty flag disagrees with occupancy");

	a_empty_words: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_empty |->
			(rsp.front_value == EMPTY_WORD) && (rsp.rear_value == EMPTY_WORD))
		else $error("empty deque shows a word");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.occupancy <= OCC_W'(CAPACITY)))
		else $error("occupancy above capacity");

endmodule

bind double_ended_queue_unit dqu_checker u_dqu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

[dv/testbench.sv]
// Self-checking testbench for the double-ended queue unit: random and directed transfers.
module testbench;
	import dqu_pkg::*;

	class deque_scoreboard;
		logic signed [WORD_W-1:0] words [CAPACITY];
		int   head;
		int   fill;
		rsp_t expected_rsps [$];
		int   errors;
		int   n_reqs;
		int   n_overflows;
		int   n_underflows;
		int   peak_fill;

		function new();
			head         = 0;
			fill         = 0;
			errors       = 0;
			n_reqs       = 0;
			n_overflows  = 0;
			n_underflows = 0;
			peak_fill    = 0;
		endfunction

		function void note_req(req_t r);
			rsp_t e;
			e        = '0;
			e.status = STAT_OK;
			n_reqs++;
			case (r.req_type)
				REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
					if (fill >= CAPACITY) begin
						e.status = STAT_OVERFLOW;
						n_overflows++;
					end else if (r.req_type == REQ_PUSH_FRONT) begin
						head        = (head == 0) ? CAPACITY - 1 : head - 1;
						words[head] = r.push_value;
						fill++;
					end else begin
						words[(head + fill) % CAPACITY] = r.push_value;
						fill++;
					end
				end
				default: begin
					if (fill == 0) begin
						e.status = STAT_UNDERFLOW;
						n_underflows++;
					end else begin
						if (r.req_type == REQ_POP_FRONT) head = (head + 1) % CAPACITY;
						fill--;
					end
				end
			endcase
			if (fill > peak_fill) peak_fill = fill;
			if (fill != 0) begin
				e.front_value = words[head];
				e.rear_value  = words[(head + fill - 1) % CAPACITY];
			end else begin
				e.front_value = EMPTY_WORD;
				e.rear_value  = EMPTY_WORD;
			end
			e.occupancy = OCC_W'(fill);
			e.is_empty  = (fill == 0);
			expected_rsps.push_back(e);
		endfunction

		function void check_rsp(rsp_t a);
			rsp_t e;
			if (expected_rsps.size() == 0) begin
				$error("unexpected result transfer: status %0d front %0d", a.status,
					a.front_value);
				errors++;
				return;
			end
			e = expected_rsps.pop_front();
			if (a.status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, a.status);
				errors++;
			end
			if (a.front_value !== e.front_value) begin
				$error("front_value: expected %0d, actual %0d", e.front_value, a.front_value);
				errors++;
			end
			if (a.rear_value !== e.rear_value) begin
				$error("rear_value: expected %0d, actual %0d", e.rear_value, a.rear_value);
				errors++;
			end
			if (a.occupancy !== e.occupancy) begin
				$error("occupancy: expected %0d, actual %0d", e.occupancy, a.occupancy);
				errors++;
			end
			if (a.is_empty !== e.is_empty) begin
				$error("is_empty: expected %0d, actual %0d", e.is_empty, a.is_empty);
				errors++;
			end
		endfunction

		function int pending();
			return expected_rsps.size();
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int src_idle_pct = 0;
	int snk_stall_pct = 0;

	deque_scoreboard sb = new();

	double_ended_queue_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < snk_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) sb.note_req(req);
			if (rsp_valid && !rsp_stall) sb.check_rsp(rsp);
		end
	end

	task automatic send_req(input logic [1:0] kind, input logic signed [WORD_W-1:0] value);
		logic accepted;
		accepted = 1'b0;
		while ($urandom_range(99) < src_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid      <= 1'b1;
		req.req_type   <= kind;
		req.push_value <= value;
		while (!accepted) begin
			@(posedge clk);
			accepted = !req_stall;
			@(negedge clk);
		end
	endtask

	function automatic logic signed [WORD_W-1:0] pick_word();
		case ($urandom_range(7))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return EMPTY_WORD;
			3:       return '0;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(input int n_items);
		int run_left;
		int push_pct;
		logic [1:0] kind;
		run_left = 0;
		push_pct = 50;
		for (int i = 0; i < n_items; i++) begin
			if (run_left == 0) begin
				run_left = $urandom_range(40, 8);
				case ($urandom_range(2))
					0:       push_pct = 85;
					1:       push_pct = 15;
					default: push_pct = 50;
				endcase
			end
			run_left--;
			if ($urandom_range(99) < push_pct)
				kind = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_REAR;
			else
				kind = $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_REAR;
			send_req(kind, pick_word());
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty pops, a stored all-ones word, extreme words, then fill past full
		send_req(REQ_POP_FRONT, pick_word());
		send_req(REQ_POP_REAR, pick_word());
		send_req(REQ_PUSH_FRONT, EMPTY_WORD);
		send_req(REQ_POP_REAR, pick_word());
		send_req(REQ_PUSH_REAR, 32'sh7fff_ffff);
		send_req(REQ_PUSH_FRONT, 32'sh8000_0000);
		send_req(REQ_POP_FRONT, pick_word());
		send_req(REQ_POP_REAR, pick_word());
		for (int i = 0; i < CAPACITY; i++)
			send_req((i % 2) ? REQ_PUSH_REAR : REQ_PUSH_FRONT, $urandom);
		send_req(REQ_PUSH_FRONT, 32'sh5555_5555);
		send_req(REQ_PUSH_REAR, 32'shaaaa_aaaa);

		random_phase(125);
		src_idle_pct  = 67;
		snk_stall_pct = 0;
		random_phase(125);
		src_idle_pct  = 0;
		snk_stall_pct = 67;
		random_phase(125);
		src_idle_pct  = 30;
		snk_stall_pct = 30;
		random_phase(125);

		req_valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("ran %0d requests: %0d overflows, %0d underflows, peak fill %0d of %0d",
			sb.n_reqs, sb.n_overflows, sb.n_underflows, sb.peak_fill, CAPACITY);
		$display("idle mixes covered: none, sender 67%%, receiver 67%%, both 30%%");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("** double_ended_queue_unit: PASSED **");
		end else begin
			$display("** double_ended_queue_unit: FAILED **");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("timeout with %0d results outstanding", sb.pending());
		$display("** double_ended_queue_unit: FAILED **");
		$finish;
	end

endmodule
